### hw/rtl/lpe_pkg.sv
// ============================================================================
// lpe_pkg: shared definitions for the Laguerre polynomial evaluator
// Widths, fixed-point constants, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package lpe_pkg;

  // Fixed-point format and order limit.
  localparam int FRAC_BITS = 16;
  localparam int MAX_ORDER = 31;

  // Field widths.
  localparam int X_W   = 32;                       // x and alpha, Q16.16
  localparam int V_W   = 48;                       // recurrence values, Q32.16
  localparam int ORD_W = 5;                        // order register
  localparam int IDX_W = $clog2(MAX_ORDER + 1);    // step index i

  // Datapath widths.
  localparam int A_W    = X_W + 2;                 // coefficients a and b
  localparam int HALF_W = V_W / 2;                 // value split for the multiplier
  localparam int PROD_W = A_W + HALF_W + 1;        // one partial product
  localparam int ACC_W  = A_W + V_W + 1;           // exact numerator
  localparam int SHR_W  = ACC_W - FRAC_BITS;       // numerator magnitude >> FRAC_BITS
  localparam int THR_W  = IDX_W + V_W - 1;         // saturation threshold i * 2^47

  // Divider: dividend width and bits retired per cycle.
  localparam int DIV_RADIX = 8;
  localparam int DVD_W     = 56;
  localparam int DIV_STEPS = DVD_W / DIV_RADIX;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = X_W;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b1;

  // Constant values.
  localparam logic [V_W-1:0] ONE_VAL = V_W'(1) << FRAC_BITS;
  localparam logic [V_W-1:0] VAL_MAX = {1'b0, {(V_W-1){1'b1}}};
  localparam logic [V_W-1:0] VAL_MIN = {1'b1, {(V_W-1){1'b0}}};

  // Controller to datapath.
  typedef struct packed {
    logic       load;       // latch x, start a new item
    logic       mul;        // issue one partial product
    logic [1:0] pp_sel;     // bit 1: b*v_prev term, bit 0: low half of value
    logic       div_start;  // form magnitude, check saturation, start divider
    logic       update;     // write back the new value, advance i
    logic       emit;       // load the output register
  } lpe_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic short_order;      // order 0 or 1, no recurrence steps
    logic last_step;        // current i equals the order
    logic div_done;         // divider quotient is ready
  } lpe_sts_t;

endpackage

`default_nettype wire

### hw/rtl/lpe_if.sv
// ============================================================================
// lpe_in_if / lpe_out_if: valid/ready channels of the evaluator
// One channel carries evaluation points in, the other carries results out.
// ============================================================================
`default_nettype none

interface lpe_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [lpe_pkg::X_W-1:0]   point_x;

  modport source (output valid, output point_x, input ready);
  modport sink   (input valid, input point_x, output ready);
endinterface

interface lpe_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lpe_pkg::V_W-1:0]   poly_value;
  logic                             overflow_flag;

  modport source (output valid, output poly_value, output overflow_flag, input ready);
  modport sink   (input valid, input poly_value, input overflow_flag, output ready);
endinterface

`default_nettype wire

### hw/rtl/lpe_div.sv
// ============================================================================
// lpe_div: iterative divider by a small integer
// Restoring division, DIV_RADIX quotient bits per cycle.
// ============================================================================
`default_nettype none

module lpe_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lpe_pkg::DVD_W-1:0]   dividend_i,
  input  logic [lpe_pkg::IDX_W-1:0]   divisor_i,
  output logic [lpe_pkg::DVD_W-1:0]   quot_o,
  output logic                        done_o
);

  logic [lpe_pkg::DVD_W-1:0]  work_q, work_d;
  logic [lpe_pkg::IDX_W-1:0]  rem_q, rem_d;
  logic [lpe_pkg::IDX_W-1:0]  dvs_q;
  logic [lpe_pkg::IDX_W:0]    trial;
  logic [lpe_pkg::DCNT_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;

  // The work register shifts the dividend out at the top and collects
  // quotient bits at the bottom.
  always_comb begin
    rem_d  = rem_q;
    work_d = work_q;
    trial  = '0;
    for (int k = 0; k < lpe_pkg::DIV_RADIX; k++) begin
      trial  = {rem_d, work_d[lpe_pkg::DVD_W-1]};
      work_d = {work_d[lpe_pkg::DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial     = trial - {1'b0, dvs_q};
        work_d[0] = 1'b1;
      end
      rem_d = trial[lpe_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == lpe_pkg::DCNT_W'(lpe_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_o = work_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### hw/rtl/lpe_dpath.sv
// ============================================================================
// lpe_dpath: recurrence datapath
// Holds the configuration registers, the two recurrence values, the shared
// multiplier with its numerator accumulator, and the divider.
// ============================================================================
`default_nettype none

module lpe_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lpe_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lpe_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [lpe_pkg::X_W-1:0]      x_i,
  input  lpe_pkg::lpe_cmd_t                   cmd_i,
  output lpe_pkg::lpe_sts_t                   sts_o,
  output logic signed [lpe_pkg::V_W-1:0]      poly_value_o,
  output logic                                overflow_flag_o
);

  // Configuration.
  logic [lpe_pkg::ORD_W-1:0]          order_q;
  logic signed [lpe_pkg::X_W-1:0]     alpha_q;
  logic [lpe_pkg::IDX_W-1:0]          n_eff;

  // Item state.
  logic signed [lpe_pkg::X_W-1:0]     x_q;
  logic [lpe_pkg::IDX_W-1:0]          i_q;
  logic signed [lpe_pkg::V_W-1:0]     vprev_q, vcur_q;
  logic                               ovf_q;

  // Coefficients.
  logic signed [lpe_pkg::A_W-1:0]     alpha_a, x_a, ld_x_a, one_a, v1_w;
  logic [lpe_pkg::IDX_W:0]            twoim1;
  logic signed [lpe_pkg::A_W-1:0]     a_term, b_term, a_w, b_w;

  // Multiplier and accumulator.
  logic signed [lpe_pkg::A_W-1:0]     op_a;
  logic signed [lpe_pkg::V_W-1:0]     vsel;
  logic signed [lpe_pkg::HALF_W:0]    op_b;
  logic signed [lpe_pkg::PROD_W-1:0]  prod_q;
  logic                               prod_vld_q, prod_hi_q, prod_neg_q;
  logic signed [lpe_pkg::ACC_W-1:0]   pp_ext, pp_shf, acc_q;

  // Division setup and write-back.
  logic                               num_neg;
  logic [lpe_pkg::ACC_W-1:0]          acc_u, num_mag;
  logic [lpe_pkg::SHR_W-1:0]          num_shr;
  logic [lpe_pkg::THR_W-1:0]          sat_thr;
  logic                               sat_w;
  logic                               neg_q, sat_q;
  logic [lpe_pkg::DVD_W-1:0]          quot;
  logic [lpe_pkg::V_W-1:0]            q_v, res_w;
  logic                               div_done;

  // Output register payload.
  logic signed [lpe_pkg::V_W-1:0]     out_val_q;
  logic                               out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
      alpha_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpe_pkg::REG_ORDER: order_q <= cfg_data_i[lpe_pkg::ORD_W-1:0];
        lpe_pkg::REG_ALPHA: alpha_q <= cfg_data_i;
      endcase
    end
  end

  assign n_eff = (int'(order_q) > lpe_pkg::MAX_ORDER) ? lpe_pkg::IDX_W'(lpe_pkg::MAX_ORDER)
                                                      : lpe_pkg::IDX_W'(order_q);

  // a = ((2i-1) << F) + alpha - x, b = ((i-1) << F) + alpha.
  assign alpha_a = lpe_pkg::A_W'(alpha_q);
  assign x_a     = lpe_pkg::A_W'(x_q);
  assign ld_x_a  = lpe_pkg::A_W'(x_i);
  assign one_a   = lpe_pkg::A_W'(lpe_pkg::ONE_VAL);
  assign v1_w    = one_a + alpha_a - ld_x_a;
  assign twoim1  = {i_q, 1'b0} - (lpe_pkg::IDX_W + 1)'(1);
  assign a_term  = lpe_pkg::A_W'(twoim1) << lpe_pkg::FRAC_BITS;
  assign b_term  = lpe_pkg::A_W'(i_q - lpe_pkg::IDX_W'(1)) << lpe_pkg::FRAC_BITS;
  assign a_w     = a_term + alpha_a - x_a;
  assign b_w     = b_term + alpha_a;

  // Each value is split into a signed high half and an unsigned low half, so
  // one numerator takes four passes through the multiplier.
  assign op_a = cmd_i.pp_sel[1] ? b_w : a_w;
  assign vsel = cmd_i.pp_sel[1] ? vprev_q : vcur_q;
  assign op_b = cmd_i.pp_sel[0]
              ? $signed({1'b0, vsel[lpe_pkg::HALF_W-1:0]})
              : (lpe_pkg::HALF_W + 1)'($signed(vsel[lpe_pkg::V_W-1:lpe_pkg::HALF_W]));

  assign pp_ext = lpe_pkg::ACC_W'(prod_q);
  assign pp_shf = prod_hi_q ? (pp_ext <<< lpe_pkg::HALF_W) : pp_ext;

  // Magnitude of the numerator, truncated by 2^F. Dividing that by i gives
  // the same quotient as dividing the numerator by i << F.
  assign acc_u   = acc_q;
  assign num_neg = acc_q[lpe_pkg::ACC_W-1];
  assign num_mag = num_neg ? (~acc_u + 1'b1) : acc_u;
  assign num_shr = num_mag[lpe_pkg::ACC_W-1:lpe_pkg::FRAC_BITS];
  // A negative quotient may reach 2^47 before it clamps, a positive one 2^47-1.
  assign sat_thr = (lpe_pkg::THR_W'(i_q) << (lpe_pkg::V_W - 1))
                 | (num_neg ? lpe_pkg::THR_W'(i_q) : '0);
  assign sat_w   = num_shr >= lpe_pkg::SHR_W'(sat_thr);

  lpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_shr[lpe_pkg::DVD_W-1:0]),
    .divisor_i  (i_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign q_v   = quot[lpe_pkg::V_W-1:0];
  assign res_w = sat_q ? (neg_q ? lpe_pkg::VAL_MIN : lpe_pkg::VAL_MAX)
                       : (neg_q ? ('0 - q_v) : q_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_i;
      i_q     <= lpe_pkg::IDX_W'(2);
      vprev_q <= $signed(lpe_pkg::ONE_VAL);
      vcur_q  <= lpe_pkg::V_W'(v1_w);
      ovf_q   <= 1'b0;
    end else if (cmd_i.update) begin
      i_q     <= i_q + 1'b1;
      vprev_q <= vcur_q;
      vcur_q  <= $signed(res_w);
      ovf_q   <= ovf_q | sat_q;
    end

    if (cmd_i.mul) begin
      prod_q     <= op_a * op_b;
      prod_hi_q  <= ~cmd_i.pp_sel[0];
      prod_neg_q <= cmd_i.pp_sel[1];
    end

    priority if (cmd_i.mul && cmd_i.pp_sel == 2'b00) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= prod_neg_q ? (acc_q - pp_shf) : (acc_q + pp_shf);
    end

    if (cmd_i.div_start) begin
      neg_q <= num_neg;
      sat_q <= sat_w;
    end

    if (cmd_i.emit) begin
      out_val_q <= (n_eff == lpe_pkg::IDX_W'(0)) ? $signed(lpe_pkg::ONE_VAL) : vcur_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign sts_o.short_order = n_eff <= lpe_pkg::IDX_W'(1);
  assign sts_o.last_step   = i_q == n_eff;
  assign sts_o.div_done    = div_done;

  assign poly_value_o    = out_val_q;
  assign overflow_flag_o = out_ovf_q;

endmodule

`default_nettype wire

### hw/rtl/lpe_ctrl.sv
// ============================================================================
// lpe_ctrl: sequencer of the Laguerre evaluator
// Walks each item through load, the multiply passes, the division and the
// write-back of every recurrence step, and owns the output valid flag.
// ============================================================================
`default_nettype none

module lpe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  lpe_pkg::lpe_sts_t   sts_i,
  output lpe_pkg::lpe_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  localparam logic [1:0] PP_LAST = 2'b11;

  logic [2:0] state_q, state_d;
  logic [1:0] pp_q, pp_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    pp_d        = pp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        pp_d    = '0;
        state_d = sts_i.short_order ? S_FIN : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul    = 1'b1;
        cmd_o.pp_sel = pp_q;
        pp_d         = pp_q + 1'b1;
        if (pp_q == PP_LAST) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last partial product is accumulated in this cycle.
        state_d = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        pp_d         = '0;
        state_d      = sts_i.last_step ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pp_q        <= pp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/laguerre_polynomial_eval.sv
// ============================================================================
// laguerre_polynomial_eval: generalized Laguerre polynomial evaluator
// Evaluates L(n, alpha, x) by the three-term recurrence in signed fixed point.
// ============================================================================
//
// Each point x (signed Q16.16) that is transferred on the input channel gives
// one transfer on the output channel: L(n, alpha, x) as signed Q32.16, clamped
// to the 48-bit range, together with a flag that is set when any recurrence
// step had to be clamped (later steps then go on from the clamped value).
// The order n (register 0, five bits) and alpha (register 1, signed Q16.16)
// must be written through the configuration port while the block is idle,
// which the block does not enforce. Order zero returns 1.0 and order one
// returns 1 + alpha - x without any step. Every step from i = 2 to n forms
// the exact numerator a*v(i-1) - b*v(i-2) with one shared multiplier in four
// passes (each value is split into two 24-bit halves), then divides its
// magnitude by i << 16 in an iterative divider that retires eight quotient
// bits per cycle, and the quotient is truncated toward zero. Each step runs
// through the four multiply passes, a drain of the accumulator, the setup of
// the division, the divider's iterations and the state in which the sequencer
// sees the divider done, and the write-back. The block works on one item at a
// time; a finished result sits in the output register, and a new point is
// taken while that result still waits to be transferred.
//
`default_nettype none

module laguerre_polynomial_eval (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lpe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  lpe_in_if.sink                            in_ch,
  lpe_out_if.source                         out_ch
);

  lpe_pkg::lpe_cmd_t cmd;
  lpe_pkg::lpe_sts_t sts;

  // The sequencer decides what happens each cycle and handles both channels.
  lpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, arithmetic and the result payload.
  lpe_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .x_i             (in_ch.point_x),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .poly_value_o    (out_ch.poly_value),
    .overflow_flag_o (out_ch.overflow_flag)
  );

endmodule

`default_nettype wire
